// ----- sv/cdq_pkg.sv -----
// Package for the circular deque: action and status codes, the command
// passed from the front queue to the back end, and the default depth.
// No dependencies.
package cdq_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 8;

  localparam logic [1:0] ACT_PUSH_RIGHT = 2'd0;
  localparam logic [1:0] ACT_PUSH_LEFT  = 2'd1;
  localparam logic [1:0] ACT_POP_LEFT   = 2'd2;
  localparam logic [1:0] ACT_POP_RIGHT  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                     is_push;
    logic                     at_left;
    logic signed [DATA_W-1:0] value;
  } cdq_cmd_t;

endpackage

// ----- sv/cdq_if.sv -----
// Request and response channels of the circular deque.
// Depends on cdq_pkg.
interface cdq_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic signed [cdq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [cdq_pkg::DATA_W-1:0] pop_value;
  logic                             is_empty;
  logic                             is_full;

  modport source (output valid, status, pop_value, is_empty, is_full, input ready);
  modport sink   (input valid, status, pop_value, is_empty, is_full, output ready);
endinterface

// ----- sv/cdq_front.sv -----
// Front end: accept request items, decode the action and hold them in a
// two-entry command queue. Depends on cdq_pkg and cdq_req_if.
module cdq_front (
  input  logic              clk,
  input  logic              rst,
  cdq_req_if.sink           req,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  cdq_cmd_t   q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  cdq_cmd_t   dec;
  logic       take;
  logic       give;

  // decode the action into push/pop and end
  always_comb begin
    dec.value = req.push_value;
    unique case (req.action)
      ACT_PUSH_RIGHT: begin dec.is_push = 1'b1; dec.at_left = 1'b0; end
      ACT_PUSH_LEFT:  begin dec.is_push = 1'b1; dec.at_left = 1'b1; end
      ACT_POP_LEFT:   begin dec.is_push = 1'b0; dec.at_left = 1'b1; end
      ACT_POP_RIGHT:  begin dec.is_push = 1'b0; dec.at_left = 1'b0; end
      default:        begin dec.is_push = 1'b0; dec.at_left = 1'b0; end
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign take      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign give      = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (take && !give) count_next = count + 2'd1;
    else if (!take && give) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (take) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) wr_ptr <= !wr_ptr;
      if (give) rd_ptr <= !rd_ptr;
      count <= count_next;
    end
  end

  property p_no_overfill;
    @(posedge clk) disable iff (rst) (count == 2'd2) |-> !take;
  endproperty
  a_no_overfill: assert property (p_no_overfill) else $error("command queue overfilled");

  property p_count_step;
    @(posedge clk) disable iff (rst)
      (take && !give) |=> (count == $past(count) + 2'd1);
  endproperty
  a_count_step: assert property (p_count_step) else $error("queue count not advanced");

  property p_empty_no_give;
    @(posedge clk) disable iff (rst) (count == 2'd0) |-> !give;
  endproperty
  a_empty_no_give: assert property (p_empty_no_give) else $error("command taken from empty queue");

endmodule

// ----- sv/cdq_back.sv -----
// Back end: end pointers, the circular store and the response register.
// Depends on cdq_pkg and cdq_rsp_if.
module cdq_back #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cdq_pkg::cdq_cmd_t cmd,
  cdq_rsp_if.source         rsp
);
  import cdq_pkg::*;

  localparam int            AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  function automatic logic [AW-1:0] wrap_up(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_down(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [0:0]        state;
  logic [AW-1:0]     left_pos;
  logic [AW-1:0]     right_pos;
  logic              empty_flag;
  logic [AW-1:0]     left_pos_next;
  logic [AW-1:0]     right_pos_next;
  logic              empty_flag_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [1:0]        stat_c;
  logic              full_now;
  logic              full_after;
  logic              go;
  logic              out_free;

  logic              out_valid;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_value;
  logic              out_empty;
  logic              out_full;
  logic              pend_empty;
  logic              pend_full;

  assign out_free  = !out_valid || rsp.ready;
  assign go        = (state == ST_IDLE) && cmd_valid && out_free;
  assign cmd_ready = go;
  assign full_now  = !empty_flag && (wrap_up(right_pos) == left_pos);

  always_comb begin
    left_pos_next   = left_pos;
    right_pos_next  = right_pos;
    empty_flag_next = empty_flag;
    wr_en   = 1'b0;
    wr_addr = '0;
    rd_en   = 1'b0;
    rd_addr = left_pos;
    stat_c  = STAT_OK;
    if (cmd.is_push) begin
      if (full_now) begin
        stat_c = STAT_OVERFLOW;
      end else if (empty_flag) begin
        left_pos_next   = '0;
        right_pos_next  = '0;
        empty_flag_next = 1'b0;
        wr_en   = go;
        wr_addr = '0;
      end else if (!cmd.at_left) begin
        right_pos_next = wrap_up(right_pos);
        wr_en   = go;
        wr_addr = right_pos_next;
      end else begin
        left_pos_next = wrap_down(left_pos);
        wr_en   = go;
        wr_addr = left_pos_next;
      end
    end else begin
      if (empty_flag) begin
        stat_c = STAT_UNDERFLOW;
      end else begin
        rd_en   = go;
        rd_addr = cmd.at_left ? left_pos : right_pos;
        if (left_pos == right_pos) begin
          left_pos_next   = '0;
          right_pos_next  = '0;
          empty_flag_next = 1'b1;
        end else if (cmd.at_left) begin
          left_pos_next = wrap_up(left_pos);
        end else begin
          right_pos_next = wrap_down(right_pos);
        end
      end
    end
    full_after = !empty_flag_next && (wrap_up(right_pos_next) == left_pos_next);
  end

  // store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pend_empty <= empty_flag_next;
      pend_full  <= full_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      left_pos   <= '0;
      right_pos  <= '0;
      empty_flag <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            left_pos   <= left_pos_next;
            right_pos  <= right_pos_next;
            empty_flag <= empty_flag_next;
            if (rd_en) begin
              state <= ST_READ;
              if (rsp.ready) out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_READ: begin
          state     <= ST_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go && !rd_en) begin
      out_status <= stat_c;
      out_value  <= '0;
      out_empty  <= empty_flag_next;
      out_full   <= full_after;
    end else if (state == ST_READ) begin
      out_status <= STAT_OK;
      out_value  <= rd_data;
      out_empty  <= pend_empty;
      out_full   <= pend_full;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.pop_value = out_value;
  assign rsp.is_empty  = out_empty;
  assign rsp.is_full   = out_full;

  property p_read_slot_free;
    @(posedge clk) disable iff (rst) (state == ST_READ) |-> !out_valid;
  endproperty
  a_read_slot_free: assert property (p_read_slot_free) else $error("response slot busy during read");

  property p_pop_reads;
    @(posedge clk) disable iff (rst) (go && rd_en) |=> (state == ST_READ);
  endproperty
  a_pop_reads: assert property (p_pop_reads) else $error("pop did not enter read state");

  property p_empty_ptrs;
    @(posedge clk) disable iff (rst) empty_flag |-> (left_pos == '0 && right_pos == '0);
  endproperty
  a_empty_ptrs: assert property (p_empty_ptrs) else $error("empty deque with moved pointers");

  property p_flags_apart;
    @(posedge clk) disable iff (rst) (out_valid && out_empty) |-> !out_full;
  endproperty
  a_flags_apart: assert property (p_flags_apart) else $error("response both empty and full");

endmodule

// ----- sv/circular_deque_top.sv -----
// Top level of the circular deque: front command queue and back end.
// Depends on cdq_pkg, cdq_if, cdq_front and cdq_back.
//
//   channel | dir | fields                                     | accepted when
//   req     | in  | action[1:0], push_value[31:0]              | valid && ready
//   rsp     | out | status[1:0], pop_value[31:0], is_empty,    | valid && ready
//           |     | is_full                                    |
//
// A push, or any action that fails, is answered from the back end's idle
// state; a successful pop adds the read state: the store's read is registered.
// The front holds up to two decoded items, so requests keep arriving while
// the back end works or waits for the response to be taken.
// Reset (rst, synchronous) empties the deque; store contents are not cleared,
// since a pop only ever reads a slot that a push has written.
// A stalled response holds the back end; the front then fills and drops ready.
module circular_deque_top #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);
  import cdq_pkg::*;

  logic     cmd_valid;
  logic     cmd_ready;
  cdq_cmd_t cmd;

  // accept and decode requests
  cdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // advance pointers, access the store, hold the response
  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule
